### hw/rtl/stmr_pkg.sv
package stmr_pkg;

    localparam int DEF_NUM_SLOTS = 16;
    localparam int DEF_TIME_BITS = 32;

    localparam int SLOT_W      = 4;
    localparam int PERIOD_W    = 24;
    localparam int TAG_W       = 32;
    localparam int FIRE_TIME_W = 32;

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 3;
    localparam int M_PAD_W   = M_TDATA_W - (SLOT_W + TAG_W + FIRE_TIME_W + 1);

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_ARM    = 2'd1,
        OP_CANCEL = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_FIRED     = 3'd0,
        KIND_ARMED     = 3'd1,
        KIND_CANCELLED = 3'd2,
        KIND_REJECTED  = 3'd3,
        KIND_CLEARED   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ALU_INC      = 2'd0,
        ALU_PERIOD   = 2'd1,
        ALU_INTERVAL = 2'd2
    } alu_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_ARM   = 3'd1,
        ST_TICK  = 3'd2,
        ST_SCAN  = 3'd3,
        ST_FLUSH = 3'd4
    } state_t;

    typedef struct packed {
        kind_t                  kind;
        logic [SLOT_W-1:0]      slot;
        logic [TAG_W-1:0]       tag;
        logic [FIRE_TIME_W-1:0] fire_time;
        logic                   once;
    } res_t;

endpackage

### hw/rtl/multi_slot_software_timer_unit.sv
// Multi-slot tick timer.
// Input stream s_axis: one beat per request; tuser carries the opcode (tick, arm,
// cancel, clear), tdata the slot, period, one-shot flag and tag.
// Output stream m_axis: one beat per result; tuser carries the result kind, tlast
// marks the final beat caused by a request.
// Cancel, clear and a rejected arm answer with a single beat by way of ST_FLUSH,
// an accepted arm by way of ST_ARM and then ST_FLUSH, and s_axis_tready rises again
// once that beat is in the output register.
// A tick runs ST_TICK, ST_SCAN and, if any slot fires, ST_FLUSH: ST_TICK advances
// the counter, then, unless the output stalls, one slot per cycle is read from the
// slot memory and compared against the new count by the single adder/comparator,
// which also computes the re-arm deadline; ST_FLUSH hands over the last fired beat.
// Fired slots come out in ascending slot order; none when nothing is due.
// s_axis_tready is low while a request is being worked on.
// When m_axis_tready is held low the scan holds on the next due slot and the
// request side stays stalled until the beat ahead has been taken.
// Reset clears the counter and disarms every slot; slot contents are
// undefined until armed and need no clearing pass.
module multi_slot_software_timer_unit
    import stmr_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS,
    parameter int TIME_BITS = DEF_TIME_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // slot[3:0], period[27:4], one_shot[28], tag[60:29], zero[63:61]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // opcode[1:0]
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // slot_out[3:0], tag_out[35:4], fire_time[67:36], was_one_shot[68], zero[71:69]
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // kind[2:0]
    output logic [M_TUSER_W-1:0] m_axis_tuser,
    output logic                 m_axis_tlast
);

    localparam int IDX_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int ENTRY_W = TIME_BITS + PERIOD_W + 1 + TAG_W;

    state_t               state_reg, state_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [NUM_SLOTS-1:0] armed_reg, armed_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 pend_valid_reg, pend_valid_next;
    res_t                 pend_reg, pend_next;

    logic [SLOT_W-1:0]    slot_reg;
    logic [PERIOD_W-1:0]  period_reg;
    logic                 once_reg;
    logic [TAG_W-1:0]     tag_reg;

    logic                 m_valid_reg;
    res_t                 out_reg, out_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_load;
    logic                 out_free;

    op_t                  in_op;
    logic [SLOT_W-1:0]    in_slot;
    logic [PERIOD_W-1:0]  in_period;
    logic                 in_once;
    logic [TAG_W-1:0]     in_tag;
    logic                 in_bad;
    logic                 in_load;

    alu_sel_t             alu_sel;
    logic [TIME_BITS-1:0] alu_sum;
    logic                 alu_due;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;

    logic [TAG_W-1:0]     rd_tag;
    logic                 rd_once;
    logic [PERIOD_W-1:0]  rd_interval;
    logic [TIME_BITS-1:0] rd_deadline;

    logic [IDX_W-1:0]     arm_idx;
    logic                 hit;
    logic                 scan_end;

    function automatic res_t make_ack(kind_t kind, logic [SLOT_W-1:0] slot,
                                      logic [FIRE_TIME_W-1:0] stamp);
        res_t r;
        r.kind      = kind;
        r.slot      = slot;
        r.tag       = '0;
        r.fire_time = stamp;
        r.once      = 1'b0;
        return r;
    endfunction

    assign in_op     = op_t'(s_axis_tuser);
    assign in_slot   = s_axis_tdata[SLOT_W-1:0];
    assign in_period = s_axis_tdata[SLOT_W +: PERIOD_W];
    assign in_once   = s_axis_tdata[SLOT_W + PERIOD_W];
    assign in_tag    = s_axis_tdata[SLOT_W + PERIOD_W + 1 +: TAG_W];
    assign in_bad    = (32'(in_slot) >= NUM_SLOTS);

    assign rd_tag      = ram_rdata[TAG_W-1:0];
    assign rd_once     = ram_rdata[TAG_W];
    assign rd_interval = ram_rdata[TAG_W + 1 +: PERIOD_W];
    assign rd_deadline = ram_rdata[TAG_W + 1 + PERIOD_W +: TIME_BITS];

    assign arm_idx  = IDX_W'(slot_reg);
    assign hit      = armed_reg[idx_reg] && alu_due;
    assign scan_end = (idx_reg == IDX_W'(NUM_SLOTS - 1));
    assign out_free = !m_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);

    stmr_alu #(
        .TIME_BITS (TIME_BITS)
    ) u_alu (
        .sel      (alu_sel),
        .now      (now_reg),
        .period   (period_reg),
        .interval (rd_interval),
        .deadline (rd_deadline),
        .sum      (alu_sum),
        .due      (alu_due)
    );

    stmr_ram #(
        .DEPTH (NUM_SLOTS),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        now_next        = now_reg;
        armed_next      = armed_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        in_load         = 1'b0;
        alu_sel         = ALU_INTERVAL;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = {alu_sum, rd_interval, rd_once, rd_tag};
        ram_raddr       = idx_reg;
        out_load        = 1'b0;
        out_next        = pend_reg;
        out_last_next   = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    in_load = 1'b1;
                    unique case (in_op)
                        OP_TICK:
                        begin
                            state_next = ST_TICK;
                        end
                        OP_ARM:
                        begin
                            if (in_period == '0 || in_bad)
                            begin
                                pend_next  = make_ack(KIND_REJECTED, in_slot,
                                                      FIRE_TIME_W'(now_reg));
                                state_next = ST_FLUSH;
                            end
                            else
                            begin
                                state_next = ST_ARM;
                            end
                        end
                        OP_CANCEL:
                        begin
                            if (in_bad)
                            begin
                                pend_next = make_ack(KIND_REJECTED, in_slot,
                                                     FIRE_TIME_W'(now_reg));
                            end
                            else
                            begin
                                armed_next[IDX_W'(in_slot)] = 1'b0;
                                pend_next = make_ack(KIND_CANCELLED, in_slot,
                                                     FIRE_TIME_W'(now_reg));
                            end
                            state_next = ST_FLUSH;
                        end
                        OP_CLEAR:
                        begin
                            armed_next = '0;
                            pend_next  = make_ack(KIND_CLEARED, '0, FIRE_TIME_W'(now_reg));
                            state_next = ST_FLUSH;
                        end
                    endcase
                end
            end
            ST_ARM:
            begin
                alu_sel             = ALU_PERIOD;
                ram_we              = 1'b1;
                ram_waddr           = arm_idx;
                ram_wdata           = {alu_sum, period_reg, once_reg, tag_reg};
                armed_next[arm_idx] = 1'b1;
                pend_next           = make_ack(KIND_ARMED, slot_reg, FIRE_TIME_W'(now_reg));
                state_next          = ST_FLUSH;
            end
            ST_TICK:
            begin
                alu_sel         = ALU_INC;
                now_next        = alu_sum;
                idx_next        = '0;
                ram_raddr       = '0;
                pend_valid_next = 1'b0;
                state_next      = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (!(hit && pend_valid_reg && !out_free))
                begin
                    if (hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_load      = 1'b1;
                            out_last_next = 1'b0;
                        end
                        pend_next.kind      = KIND_FIRED;
                        pend_next.slot      = SLOT_W'(idx_reg);
                        pend_next.tag       = rd_tag;
                        pend_next.fire_time = FIRE_TIME_W'(now_reg);
                        pend_next.once      = rd_once;
                        pend_valid_next     = 1'b1;
                        if (rd_once)
                        begin
                            armed_next[idx_reg] = 1'b0;
                        end
                        else
                        begin
                            ram_we = 1'b1;
                        end
                    end
                    if (scan_end)
                    begin
                        state_next = (hit || pend_valid_reg) ? ST_FLUSH : ST_IDLE;
                    end
                    else
                    begin
                        idx_next  = idx_reg + IDX_W'(1);
                        ram_raddr = idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            now_reg        <= '0;
            armed_reg      <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            armed_reg      <= armed_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (in_load)
        begin
            slot_reg   <= in_slot;
            period_reg <= in_period;
            once_reg   <= in_once;
            tag_reg    <= in_tag;
        end
        if (out_load)
        begin
            out_reg      <= out_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{M_PAD_W{1'b0}}, out_reg.once, out_reg.fire_time,
                            out_reg.tag, out_reg.slot};
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_last_reg;

endmodule

### hw/rtl/stmr_ram.sv
module stmr_ram
    import stmr_pkg::*;
#(
    parameter int DEPTH = DEF_NUM_SLOTS,
    parameter int WIDTH = DEF_TIME_BITS + PERIOD_W + 1 + TAG_W,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/stmr_alu.sv
module stmr_alu
    import stmr_pkg::*;
#(
    parameter int TIME_BITS = DEF_TIME_BITS
)
(
    input  alu_sel_t             sel,
    input  logic [TIME_BITS-1:0] now,
    input  logic [PERIOD_W-1:0]  period,
    input  logic [PERIOD_W-1:0]  interval,
    input  logic [TIME_BITS-1:0] deadline,
    output logic [TIME_BITS-1:0] sum,
    output logic                 due
);

    logic [TIME_BITS-1:0] operand;

    always_comb
    begin
        unique case (sel)
            ALU_INC:      operand = TIME_BITS'(1);
            ALU_PERIOD:   operand = TIME_BITS'(period);
            ALU_INTERVAL: operand = TIME_BITS'(interval);
            default:      operand = '0;
        endcase
    end

    assign sum = now + operand;
    assign due = (deadline == now);

endmodule
